// ----- src/pap_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pap_pkg - shared types and constants for the polygon area/perimeter block
// Control word layout, step addresses, jump conditions and fixed result widths.
// ----------------------------------------------------------------------------
package pap_pkg;

	// Result field widths and limits
	localparam int AREA_W  = 41;
	localparam int PERIM_W = 26;
	localparam int COUNT_W = 9;
	localparam int CROSS_W = 42;
	localparam int OUT_W   = 80;

	localparam logic [CROSS_W-1:0] CROSS_LIM = {1'b0, {(CROSS_W-1){1'b1}}};
	localparam logic [PERIM_W-1:0] PERIM_MAX = {PERIM_W{1'b1}};

	// Microprogram step addresses
	typedef logic [3:0] upc_t;

	localparam upc_t UA_WAIT  = 4'd0;
	localparam upc_t UA_CHK   = 4'd1;
	localparam upc_t UA_DIFF  = 4'd2;
	localparam upc_t UA_MDXDX = 4'd3;
	localparam upc_t UA_MDYDY = 4'd4;
	localparam upc_t UA_MAXBY = 4'd5;
	localparam upc_t UA_MAYBX = 4'd6;
	localparam upc_t UA_TERM  = 4'd7;
	localparam upc_t UA_CROSS = 4'd8;
	localparam upc_t UA_SQRT  = 4'd9;
	localparam upc_t UA_PERIM = 4'd10;
	localparam upc_t UA_BOOK  = 4'd11;
	localparam upc_t UA_LOOP  = 4'd12;
	localparam upc_t UA_EMIT  = 4'd13;

	typedef enum logic [2:0] {
		CND_NEXT,   // advance
		CND_JUMP,   // go to target
		CND_IN,     // hold until an input transfer, then advance
		CND_CNT0,   // go to target on the first vertex
		CND_SQ,     // hold until the last root iteration, then advance
		CND_CLOSE,  // go to target after the closing edge
		CND_LAST,   // go to target on the marked vertex
		CND_OUT     // hold until the output register is free, then go to target
	} cond_t;

	typedef enum logic [1:0] {
		MS_DXDX,
		MS_DYDY,
		MS_AXBY,
		MS_AYBX
	} mul_sel_t;

	typedef enum logic [1:0] {
		AC_NONE,
		AC_LOAD,
		AC_ADD,
		AC_SUB
	} acc_op_t;

	typedef struct packed {
		cond_t    cond;
		upc_t     target;
		logic     in_ready;
		logic     ld_diff;
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  d2_op;
		acc_op_t  term_op;
		logic     cross_acc;
		logic     sq_init;
		logic     sq_step;
		logic     perim_acc;
		logic     book;
		logic     emit;
	} ctl_t;

	typedef struct packed {
		logic cnt_zero;
		logic last;
		logic close;
		logic sq_last;
	} stat_t;

	// Result item, last field (area) in the lowest bits
	typedef struct packed {
		logic               overflow;
		logic [COUNT_W-1:0] vertex_count;
		logic [PERIM_W-1:0] perimeter;
		logic [AREA_W-1:0]  area;
	} res_t;

endpackage

// ----- src/pap_ucode_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pap_ucode_rom - microprogram store
// One control word per step address; unused addresses return to the wait step.
// ----------------------------------------------------------------------------
module pap_ucode_rom (
	input  pap_pkg::upc_t pc,
	output pap_pkg::ctl_t ctl
);
	import pap_pkg::*;

	always_comb begin
		ctl = '0;
		unique case (pc)
			UA_WAIT: begin
				ctl.in_ready = 1'b1;
				ctl.cond     = CND_IN;
			end
			UA_CHK: begin
				ctl.cond   = CND_CNT0;
				ctl.target = UA_BOOK;
			end
			UA_DIFF: begin
				ctl.ld_diff = 1'b1;
			end
			UA_MDXDX: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MS_DXDX;
			end
			UA_MDYDY: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MS_DYDY;
				ctl.d2_op   = AC_LOAD;
			end
			UA_MAXBY: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MS_AXBY;
				ctl.d2_op   = AC_ADD;
			end
			UA_MAYBX: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MS_AYBX;
				ctl.term_op = AC_LOAD;
			end
			UA_TERM: begin
				ctl.term_op = AC_SUB;
			end
			UA_CROSS: begin
				ctl.cross_acc = 1'b1;
				ctl.sq_init   = 1'b1;
			end
			UA_SQRT: begin
				ctl.sq_step = 1'b1;
				ctl.cond    = CND_SQ;
			end
			UA_PERIM: begin
				ctl.perim_acc = 1'b1;
				ctl.cond      = CND_CLOSE;
				ctl.target    = UA_EMIT;
			end
			UA_BOOK: begin
				ctl.book   = 1'b1;
				ctl.cond   = CND_LAST;
				ctl.target = UA_DIFF;
			end
			UA_LOOP: begin
				ctl.cond   = CND_JUMP;
				ctl.target = UA_WAIT;
			end
			UA_EMIT: begin
				ctl.emit   = 1'b1;
				ctl.cond   = CND_OUT;
				ctl.target = UA_WAIT;
			end
			default: begin
				ctl.cond   = CND_JUMP;
				ctl.target = UA_WAIT;
			end
		endcase
	end

endmodule

// ----- src/pap_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pap_isqrt - bit-serial floor square root
// Restoring digit recurrence, one result bit per step, top power of four first.
// ----------------------------------------------------------------------------
module pap_isqrt #(
	parameter int D2W = 34,
	parameter int RW  = 17
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           init,
	input  logic           step,
	input  logic [D2W-1:0] radicand,
	output logic [RW-1:0]  root,
	output logic           last_step
);
	localparam logic [D2W-1:0] BIT_TOP = {2'b01, {(D2W-2){1'b0}}};

	logic [D2W-1:0] n_q;
	logic [D2W-1:0] root_q;
	logic [D2W-1:0] bit_q;
	logic [D2W:0]   trial;

	assign trial = {1'b0, root_q} + {1'b0, bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (init) begin
			bit_q <= BIT_TOP;
		end else if (step) begin
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (init) begin
			n_q    <= radicand;
			root_q <= '0;
		end else if (step) begin
			if ({1'b0, n_q} >= trial) begin
				n_q    <= n_q - trial[D2W-1:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
		end
	end

	assign root      = root_q[RW-1:0];
	assign last_step = bit_q[0];

endmodule

// ----- src/pap_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pap_datapath - vertex registers, shared multiplier and accumulators
// Runs one edge per pass under the control word; holds the polygon state.
// ----------------------------------------------------------------------------
module pap_datapath #(
	parameter int CW           = 16,
	parameter int MAX_VERTICES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pap_pkg::ctl_t        ctl,
	input  logic                 in_load,
	input  logic signed [CW-1:0] in_x,
	input  logic signed [CW-1:0] in_y,
	input  logic                 in_last,
	input  logic                 clear,
	output pap_pkg::stat_t       stat,
	output pap_pkg::res_t        res
);
	import pap_pkg::*;

	localparam int CNW = $clog2(MAX_VERTICES + 1);
	localparam int PW  = 2 * CW + 2;            // product and squared-distance width
	localparam int RW  = CW + 1;                // edge length width
	localparam int SW  = ((PW > CROSS_W) ? PW : CROSS_W) + 1;
	localparam int PSW = ((RW > PERIM_W) ? RW : PERIM_W) + 1;
	localparam logic [CNW-1:0] CNT_MAX = CNW'(MAX_VERTICES);

	logic signed [CW-1:0]      cur_x_q, cur_y_q;
	logic signed [CW-1:0]      first_x_q, first_y_q;
	logic signed [CW-1:0]      prev_x_q, prev_y_q;
	logic                      last_q;
	logic                      close_q;
	logic signed [CW:0]        dx_q, dy_q;
	logic signed [PW-1:0]      prod_q;
	logic [PW-1:0]             d2_q;
	logic signed [PW-1:0]      term_q;
	logic signed [CROSS_W-1:0] cross_q;
	logic [PERIM_W-1:0]        perim_q;
	logic [CNW-1:0]            cnt_q;
	logic                      over_q;

	logic signed [CW-1:0] ax, ay, bx, by;
	logic signed [CW:0]   ma, mb;
	logic signed [PW-1:0] mprod;
	logic signed [SW-1:0] csum;
	logic signed [SW-1:0] clim_p, clim_n;
	logic [CROSS_W-1:0]   cross_d;
	logic [CROSS_W-1:0]   cross_abs;
	logic [PSW-1:0]       psum;
	logic [PERIM_W-1:0]   perim_d;
	logic [RW-1:0]        root;
	logic                 sq_last;
	logic [CNW+COUNT_W-1:0] cnt_ext;

	// The closing edge runs from the marked vertex back to the first
	assign ax = close_q ? cur_x_q : prev_x_q;
	assign ay = close_q ? cur_y_q : prev_y_q;
	assign bx = close_q ? first_x_q : cur_x_q;
	assign by = close_q ? first_y_q : cur_y_q;

	always_comb begin
		unique case (ctl.mul_sel)
			MS_DXDX: begin
				ma = dx_q;
				mb = dx_q;
			end
			MS_DYDY: begin
				ma = dy_q;
				mb = dy_q;
			end
			MS_AXBY: begin
				ma = {ax[CW-1], ax};
				mb = {by[CW-1], by};
			end
			MS_AYBX: begin
				ma = {ay[CW-1], ay};
				mb = {bx[CW-1], bx};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign mprod = ma * mb;

	// Saturating shoelace accumulate
	assign clim_p = $signed({{(SW-CROSS_W){1'b0}}, CROSS_LIM});
	assign clim_n = -clim_p;
	assign csum   = $signed({{(SW-CROSS_W){cross_q[CROSS_W-1]}}, cross_q})
	              + $signed({{(SW-PW){term_q[PW-1]}}, term_q});

	always_comb begin
		priority if (csum > clim_p) begin
			cross_d = clim_p[CROSS_W-1:0];
		end else if (csum < clim_n) begin
			cross_d = clim_n[CROSS_W-1:0];
		end else begin
			cross_d = csum[CROSS_W-1:0];
		end
	end

	// Saturating perimeter accumulate
	assign psum = {{(PSW-PERIM_W){1'b0}}, perim_q} + {{(PSW-RW){1'b0}}, root};
	assign perim_d = (psum > {{(PSW-PERIM_W){1'b0}}, PERIM_MAX}) ? PERIM_MAX
	                                                            : psum[PERIM_W-1:0];

	pap_isqrt #(
		.D2W (PW),
		.RW  (RW)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.init      (ctl.sq_init),
		.step      (ctl.sq_step),
		.radicand  (d2_q),
		.root      (root),
		.last_step (sq_last)
	);

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_load) begin
			cur_x_q <= in_x;
			cur_y_q <= in_y;
		end
		if (ctl.ld_diff) begin
			dx_q <= {bx[CW-1], bx} - {ax[CW-1], ax};
			dy_q <= {by[CW-1], by} - {ay[CW-1], ay};
		end
		if (ctl.mul_en) begin
			prod_q <= mprod;
		end
		unique case (ctl.d2_op)
			AC_NONE: d2_q <= d2_q;
			AC_LOAD: d2_q <= $unsigned(prod_q);
			AC_ADD:  d2_q <= d2_q + $unsigned(prod_q);
			AC_SUB:  d2_q <= d2_q - $unsigned(prod_q);
			default: d2_q <= d2_q;
		endcase
		unique case (ctl.term_op)
			AC_NONE: term_q <= term_q;
			AC_LOAD: term_q <= prod_q;
			AC_ADD:  term_q <= term_q + prod_q;
			AC_SUB:  term_q <= term_q - prod_q;
			default: term_q <= term_q;
		endcase
		if (ctl.book) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
			if (cnt_q == '0) begin
				first_x_q <= cur_x_q;
				first_y_q <= cur_y_q;
			end
		end
	end

	// Polygon state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b0;
			close_q <= 1'b0;
			cross_q <= '0;
			perim_q <= '0;
			cnt_q   <= '0;
			over_q  <= 1'b0;
		end else begin
			if (in_load) begin
				last_q <= in_last;
			end
			if (clear) begin
				close_q <= 1'b0;
				cross_q <= '0;
				perim_q <= '0;
				cnt_q   <= '0;
				over_q  <= 1'b0;
			end else begin
				if (ctl.cross_acc) begin
					cross_q <= cross_d;
				end
				if (ctl.perim_acc) begin
					perim_q <= perim_d;
				end
				if (ctl.book) begin
					if (cnt_q >= CNT_MAX) begin
						cnt_q  <= CNT_MAX;
						over_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (last_q) begin
						close_q <= 1'b1;
					end
				end
			end
		end
	end

	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.last     = last_q;
	assign stat.close    = close_q;
	assign stat.sq_last  = sq_last;

	assign cross_abs = cross_q[CROSS_W-1] ? (~cross_q + 1'b1) : cross_q;
	assign cnt_ext   = {{COUNT_W{1'b0}}, cnt_q};

	assign res.area         = cross_abs[AREA_W-1:0];
	assign res.perimeter    = perim_q;
	assign res.vertex_count = cnt_ext[COUNT_W-1:0];
	assign res.overflow     = over_q;

	a_cnt_bound : assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("vertex count above its limit");

	a_over_sat : assert property (@(posedge clk) disable iff (!arst_n)
		over_q |-> (cnt_q == CNT_MAX))
		else $error("overflow set while count not saturated");

	a_cross_lim : assert property (@(posedge clk) disable iff (!arst_n)
		($signed(cross_q) <= $signed(CROSS_LIM)) && ($signed(cross_q) >= -$signed(CROSS_LIM)))
		else $error("shoelace sum outside its saturation range");

endmodule

// ----- src/polygon_area_perimeter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_area_perimeter - streaming shoelace area and perimeter of a polygon
// Microcoded sequencer over a shared multiplier and a bit-serial square root.
// ----------------------------------------------------------------------------
//
//  channel  | dir | fields (lowest bit first)                        | per
//  ---------+-----+--------------------------------------------------+---------
//  s_*      | in  | tdata: vertex_x, vertex_y; tlast: last_vertex    | vertex
//  m_*      | out | tdata: area, perimeter, vertex_count, overflow   | polygon
//
//  Steps: a first vertex that is not marked passes the wait, check, book
//  and return steps; every later vertex also runs an edge through the
//  multiply, cross and square root steps; the square root unit yields one
//  root bit per cycle over COORD_BITS + 1 steps, behind the single multiplier
//  that is used four times per edge. The marked vertex skips the return
//  step, runs a closing edge and then the emit step.
//  Reset: arst_n clears the step counter, the polygon sums and the output
//  valid at once; the block is ready for a vertex as soon as reset is released.
//  Stalls: the result waits in an output register; the next polygon runs
//  meanwhile and holds only at its own emit step until that register frees.
//
//  Sequencer: a 4-bit step counter addresses a read-only program; each
//  control word drives the datapath and names a jump condition and target.
//
module polygon_area_perimeter #(
	parameter int MAX_VERTICES = 256,
	parameter int COORD_BITS   = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// vertex_x [COORD_BITS-1:0], vertex_y [2*COORD_BITS-1:COORD_BITS], zero fill
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
	input  logic                                   s_tlast,   // last_vertex
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// area [40:0], perimeter [66:41], vertex_count [75:67], overflow [76], zero fill
	output logic [pap_pkg::OUT_W-1:0]              m_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready
);
	import pap_pkg::*;

	localparam int CW = COORD_BITS;

	upc_t  pc_q;
	upc_t  pc_d;
	ctl_t  ctl;
	stat_t stat;
	res_t  res;

	logic             in_xfer;
	logic             out_free;
	logic             fire;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	// Only the low COORD_BITS of each field are used, as two's complement
	logic signed [CW-1:0] in_x;
	logic signed [CW-1:0] in_y;

	assign in_x = $signed(s_tdata[CW-1:0]);
	assign in_y = $signed(s_tdata[2*CW-1:CW]);

	pap_ucode_rom u_rom (
		.pc  (pc_q),
		.ctl (ctl)
	);

	assign s_tready = ctl.in_ready;
	assign in_xfer  = s_tvalid & ctl.in_ready;
	assign out_free = !m_tvalid_q || m_tready;
	assign fire     = ctl.emit & out_free;

	// Next step: advance, jump, or hold on the current step
	always_comb begin
		unique case (ctl.cond)
			CND_NEXT:  pc_d = pc_q + 1'b1;
			CND_JUMP:  pc_d = ctl.target;
			CND_IN:    pc_d = in_xfer ? pc_q + 1'b1 : pc_q;
			CND_CNT0:  pc_d = stat.cnt_zero ? ctl.target : pc_q + 1'b1;
			CND_SQ:    pc_d = stat.sq_last ? pc_q + 1'b1 : pc_q;
			CND_CLOSE: pc_d = stat.close ? ctl.target : pc_q + 1'b1;
			CND_LAST:  pc_d = stat.last ? ctl.target : pc_q + 1'b1;
			CND_OUT:   pc_d = out_free ? ctl.target : pc_q;
			default:   pc_d = UA_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= UA_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

	pap_datapath #(
		.CW           (CW),
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.in_load (in_xfer),
		.in_x    (in_x),
		.in_y    (in_y),
		.in_last (s_tlast),
		.clear   (fire),
		.stat    (stat),
		.res     (res)
	);

	// Output register: load on emit, drop valid once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata_q <= {{(OUT_W-$bits(res_t)){1'b0}}, res};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_in_to_chk : assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (pc_q == UA_CHK))
		else $error("input transfer did not advance to the first-vertex check");

	a_emit_valid : assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid)
		else $error("emitted result not presented");

	a_no_ready_emit : assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && ctl.emit))
		else $error("input ready during the emit step");

	a_pc_range : assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= UA_EMIT)
		else $error("step counter outside the program");

endmodule

// ----- verif/pap_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pap_check - polygon result predictor and comparator
// Follows the vertex stream, keeps its own shoelace and edge-length sums, and
// matches every output transfer against the oldest predicted polygon result.
// ----------------------------------------------------------------------------
module pap_check (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [31:0]               s_tdata,   // vertex_x, vertex_y
	input  logic                      s_tlast,   // last_vertex
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [pap_pkg::OUT_W-1:0] m_tdata,   // area, perimeter, vertex_count, overflow
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	output int                        errors,
	output int                        pending
);
	import pap_pkg::*;

	localparam int     MAX_VERTICES = 256;
	localparam longint CROSS_SAT    = (longint'(1) << 41) - 1;
	localparam longint PERIM_SAT    = (longint'(1) << 26) - 1;

	longint first_x, first_y, prev_x, prev_y;
	longint cross_acc, perim_acc;
	int     seen;
	bit     over;
	res_t   polygons_due[$];
	int     fail_cnt = 0;

	assign errors = fail_cnt;

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		fail_cnt++;
	endtask

	// Floor square root, one result bit at a time from the top.
	function automatic longint floor_root(longint n);
		longint r, c;
		int     b;
		r = 0;
		for (b = 17; b >= 0; b--) begin
			c = r | (longint'(1) << b);
			if (c * c <= n)
				r = c;
		end
		return r;
	endfunction

	task automatic fold_edge(longint ax, longint ay, longint bx, longint by);
		longint dx, dy;
		dx = bx - ax;
		dy = by - ay;
		cross_acc += ax * by - ay * bx;
		if (cross_acc > CROSS_SAT)
			cross_acc = CROSS_SAT;
		else if (cross_acc < -CROSS_SAT)
			cross_acc = -CROSS_SAT;
		perim_acc += floor_root(dx * dx + dy * dy);
		if (perim_acc > PERIM_SAT)
			perim_acc = PERIM_SAT;
	endtask

	task automatic clear_polygon();
		first_x   = 0;
		first_y   = 0;
		prev_x    = 0;
		prev_y    = 0;
		cross_acc = 0;
		perim_acc = 0;
		seen      = 0;
		over      = 0;
	endtask

	task automatic take_vertex(logic [31:0] d, logic last);
		longint x, y;
		res_t   r;
		x = longint'($signed(d[15:0]));
		y = longint'($signed(d[31:16]));
		if (seen == 0) begin
			first_x = x;
			first_y = y;
		end else begin
			fold_edge(prev_x, prev_y, x, y);
		end
		prev_x = x;
		prev_y = y;
		if (seen >= MAX_VERTICES)
			over = 1'b1;
		else
			seen++;
		if (last) begin
			// close back to the first vertex, then retire the polygon
			fold_edge(x, y, first_x, first_y);
			r.area         = AREA_W'((cross_acc < 0) ? -cross_acc : cross_acc);
			r.perimeter    = PERIM_W'(perim_acc);
			r.vertex_count = COUNT_W'(seen);
			r.overflow     = over;
			polygons_due.push_back(r);
			clear_polygon();
		end
	endtask

	task automatic check_result(logic [OUT_W-1:0] d);
		res_t got, want;
		got = d[$bits(res_t)-1:0];
		if (d[OUT_W-1:$bits(res_t)] != '0)
			report_mismatch("zero fill", d[OUT_W-1:$bits(res_t)], 0);
		if (polygons_due.size() == 0) begin
			report_mismatch("result with no polygon pending", got.area, 0);
		end else begin
			want = polygons_due.pop_front();
			if (got.area != want.area)
				report_mismatch("area", got.area, want.area);
			if (got.perimeter != want.perimeter)
				report_mismatch("perimeter", got.perimeter, want.perimeter);
			if (got.vertex_count != want.vertex_count)
				report_mismatch("vertex_count", got.vertex_count, want.vertex_count);
			if (got.overflow != want.overflow)
				report_mismatch("overflow", got.overflow, want.overflow);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_polygon();
			polygons_due.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (s_tvalid && s_tready)
				take_vertex(s_tdata, s_tlast);
			pending <= polygons_due.size();
		end
	end

endmodule

// ----- verif/polygon_area_perimeter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_area_perimeter_test - stream test of the polygon area/perimeter block
// Feeds directed and random polygons with random idling on both channels,
// stalls the result side long enough to back up the vertex input, runs one
// long looping polygon past the vertex limit, and reports the verdict.
// ----------------------------------------------------------------------------
module polygon_area_perimeter_test;

	import pap_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int LAP_VERTS   = 260;    // 65 laps of the full-range square

	logic              clk = 1'b0;
	logic              arst_n;
	logic [31:0]       s_tdata;   // vertex_x [15:0], vertex_y [31:16]
	logic              s_tlast;   // last_vertex
	logic              s_tvalid;
	logic              s_tready;
	logic [OUT_W-1:0]  m_tdata;   // area, perimeter, vertex_count, overflow, fill
	logic              m_tvalid;
	logic              m_tready;

	int errors;
	int pending;

	// quiet turns idling off on both sides; hold requests go to the receiver
	bit quiet      = 1'b0;
	int hold_asks  = 0;
	int holds_done = 0;

	always #2 clk = ~clk;

	polygon_area_perimeter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	pap_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.errors   (errors),
		.pending  (pending)
	);

	// Offer one vertex after a random gap and hold it until the transfer.
	// Entered and left right after a rising edge; valid stays high when the
	// next vertex follows with no gap.
	task automatic send_vertex(logic [15:0] x, logic [15:0] y, bit last);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {y, x};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid and hold off until every predicted result has been seen.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_coord(int style);
		int sel;
		sel = $urandom_range(0, 7);
		if (style == 1 && sel < 4)
			return (sel[0]) ? 16'h7FFF : 16'h8000;
		if (style == 2 || sel == 2)
			return 16'($urandom_range(0, 64) - 32);
		if (sel == 0)
			return 16'h8000;
		if (sel == 1)
			return 16'h7FFF;
		return 16'($urandom());
	endfunction

	task automatic send_polygon(int n, int style);
		int i;
		for (i = 0; i < n; i++)
			send_vertex(pick_coord(style), pick_coord(style), i == n - 1);
	endtask

	// Walk the full-range square again and again; every lap adds the same
	// signed area and the same perimeter, and the vertex count saturates
	// and sets the overflow flag on the way.
	task automatic send_laps(bit ccw);
		logic [15:0] cx[4];
		logic [15:0] cy[4];
		int          start, i, k;
		cx[0] = 16'h7FFF; cy[0] = 16'h8000;
		cx[1] = 16'h7FFF; cy[1] = 16'h7FFF;
		cx[2] = 16'h8000; cy[2] = 16'h7FFF;
		cx[3] = 16'h8000; cy[3] = 16'h8000;
		start = $urandom_range(0, 3);
		for (i = 0; i < LAP_VERTS; i++) begin
			k = ccw ? (start + i) % 4 : (start + 4 - (i % 4)) % 4;
			send_vertex(cx[k], cy[k], i == LAP_VERTS - 1);
		end
	endtask

	// Result side: random stall per result, plus the long hold on request.
	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (holds_done != hold_asks) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end
			stall = quiet ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid && holds_done == hold_asks);
		end
	end

	// Vertex side and verdict.
	initial begin
		int rand_items;
		int n;
		int sel;
		int i;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single vertex at both corners: closing edge has zero length.
		send_vertex(16'h8000, 16'h8000, 1'b1);
		send_vertex(16'h7FFF, 16'h7FFF, 1'b1);
		// Two vertices: one edge counted both ways, no area.
		send_vertex(16'h8000, 16'h7FFF, 1'b0);
		send_vertex(16'h7FFF, 16'h8000, 1'b1);
		// Large triangle, first counterclockwise then clockwise.
		send_vertex(16'h0000, 16'h0000, 1'b0);
		send_vertex(16'h7FFF, 16'h0000, 1'b0);
		send_vertex(16'h0000, 16'h7FFF, 1'b1);
		send_vertex(16'h0000, 16'h0000, 1'b0);
		send_vertex(16'h0000, 16'h7FFF, 1'b0);
		send_vertex(16'h7FFF, 16'h0000, 1'b1);
		// Full-range square: largest edges and the largest single lap.
		send_vertex(16'h8000, 16'h8000, 1'b0);
		send_vertex(16'h7FFF, 16'h8000, 1'b0);
		send_vertex(16'h7FFF, 16'h7FFF, 1'b0);
		send_vertex(16'h8000, 16'h7FFF, 1'b1);
		// Degenerate polygon: all vertices on one point.
		send_vertex(16'h0000, 16'h0000, 1'b0);
		send_vertex(16'h0000, 16'h0000, 1'b0);
		send_vertex(16'h0000, 16'h0000, 1'b1);
		// Small square around the origin, all sign mixes.
		send_vertex(16'hFFFF, 16'hFFFF, 1'b0);
		send_vertex(16'h0001, 16'hFFFF, 1'b0);
		send_vertex(16'h0001, 16'h0001, 1'b0);
		send_vertex(16'hFFFF, 16'h0001, 1'b1);

		// Random polygons: mostly small, a few with one or two vertices.
		rand_items = 0;
		while (rand_items < 250) begin
			sel = $urandom_range(0, 99);
			if (sel < 12)
				n = $urandom_range(1, 2);
			else
				n = $urandom_range(3, 12);
			quiet = ($urandom_range(0, 5) == 0);
			send_polygon(n, $urandom_range(0, 2));
			rand_items += n;
		end
		quiet = 1'b0;

		// Back-pressure: pause until idle, then hold the result side while
		// short polygons keep coming, so the input has to stall.
		drain_results();
		hold_asks++;
		quiet = 1'b1;
		for (i = 0; i < 12; i++)
			send_polygon($urandom_range(1, 2), 0);
		quiet = 1'b0;
		drain_results();

		// Long looping polygon past the vertex limit, random direction.
		send_laps(1'($urandom_range(0, 1)));

		drain_results();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
